/* sv/window_convolution_17x17_defines.svh */
// Assertion macros for the window convolution block
`ifndef WINDOW_CONVOLUTION_17X17_DEFINES_SVH
`define WINDOW_CONVOLUTION_17X17_DEFINES_SVH
`ifndef SYNTHESIS
`define WC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define WC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define WC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/wconv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wconv_pkg;
   localparam int KERNEL_SIZE_DEF = 17;
   localparam int IN_SIZE_DEF = 144;
   localparam int SUM_W = 25;
   localparam int POS_W = 7;
   localparam int PIX_W = 8;
   localparam int COEF_W = 8;
   localparam int IDX_W = 9;
   localparam logic OP_COEFF = 1'b0;
   localparam logic OP_PIXEL = 1'b1;
endpackage
`default_nettype wire

/* sv/wconv_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface wconv_req_if import wconv_pkg::*; ();
   logic valid;
   logic ready;
   logic opcode;
   logic [IDX_W-1:0] coeff_index;
   logic signed [COEF_W-1:0] coeff_value;
   logic [PIX_W-1:0] pixel;
   logic frame_start;
   modport source (output valid, opcode, coeff_index, coeff_value, pixel, frame_start,
                   input ready);
   modport sink (input valid, opcode, coeff_index, coeff_value, pixel, frame_start,
                 output ready);
endinterface

interface wconv_rsp_if import wconv_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [SUM_W-1:0] conv_sum;
   logic [POS_W-1:0] out_row;
   logic [POS_W-1:0] out_col;
   logic frame_last;
   modport source (output valid, conv_sum, out_row, out_col, frame_last, input ready);
   modport sink (input valid, conv_sum, out_row, out_col, frame_last, output ready);
endinterface
`default_nettype wire

/* sv/window_convolution_17x17.sv */
// Throughput: one request per cycle while the output queue has room; the line buffer memory reads and writes
// one column word per cycle, and the product tree is fully pipelined.
// Reset: synchronous, clears position counters, window and valid bits;
// line buffers and kernel hold undefined contents until written.
`timescale 1ns / 1ps
`default_nettype none
`include "window_convolution_17x17_defines.svh"
module window_convolution_17x17 import wconv_pkg::*; #(
   parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
   parameter int IN_SIZE = IN_SIZE_DEF
) (
   input wire logic clock,
   input wire logic reset,
   wconv_req_if.sink req,
   wconv_rsp_if.source rsp
);
   localparam int KK = KERNEL_SIZE * KERNEL_SIZE;
   localparam int LBR = KERNEL_SIZE - 1;
   localparam int CW = $clog2(IN_SIZE);
   localparam int LV = $clog2(KK);
   localparam int DEPTH = LV + 2;
   localparam int FIFO_D = DEPTH + 2;
   localparam int FW = $clog2(FIFO_D + 1);

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic last;
      logic emit;
   } tag_type;

   // Pipeline advances unless the output queue is full
   logic [FW-1:0] count_ff, count_in;
   logic adv;
   logic acc;
   assign adv = (count_ff < FW'(FIFO_D));
   assign req.ready = adv;
   assign acc = req.valid && req.ready;

   // Delay kernel writes two stages so they line up with the product stage
   logic cw1_v_ff, cw2_v_ff;
   logic [IDX_W-1:0] cw1_idx_ff, cw2_idx_ff;
   logic [COEF_W-1:0] cw1_val_ff, cw2_val_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cw1_v_ff <= 1'b0;
         cw2_v_ff <= 1'b0;
      end else if (adv) begin
         cw1_v_ff <= acc && req.opcode == OP_COEFF && req.coeff_index < IDX_W'(KK);
         cw2_v_ff <= cw1_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         cw1_idx_ff <= req.coeff_index;
         cw1_val_ff <= req.coeff_value;
         cw2_idx_ff <= cw1_idx_ff;
         cw2_val_ff <= cw1_val_ff;
      end
   end

   // Kernel store
   logic [COEF_W-1:0] kern_ff [0:KK-1];
   always_ff @(posedge clock) begin
      if (adv && cw2_v_ff) begin
         kern_ff[cw2_idx_ff] <= cw2_val_ff;
      end
   end
   logic [KK*COEF_W-1:0] coef_flat;
   always_comb begin
      for (int i = 0; i < KK; i++) coef_flat[i*COEF_W +: COEF_W] = kern_ff[i];
   end

   // Position counters
   logic [CW-1:0] row_ff, col_ff, r_cur, c_cur;
   assign r_cur = req.frame_start ? '0 : row_ff;
   assign c_cur = req.frame_start ? '0 : col_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (acc && req.opcode == OP_PIXEL) begin
         if (c_cur == CW'(IN_SIZE - 1)) begin
            col_ff <= '0;
            row_ff <= (r_cur == CW'(IN_SIZE - 1)) ? '0 : r_cur + 1'b1;
         end else begin
            col_ff <= c_cur + 1'b1;
            row_ff <= r_cur;
         end
      end
   end

   // Stage 1: read line buffer column word, hold pixel; take the word being
   // written this cycle when a frame start lands on the same column
   logic [LBR*PIX_W-1:0] lb_mem [0:IN_SIZE-1];
   logic [LBR*PIX_W-1:0] rd_ff;
   logic [LBR*PIX_W-1:0] col_word;
   logic s1_v_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   tag_type s1_tag_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= (s1_v_ff && s1_col_ff == c_cur) ? col_word : lb_mem[c_cur];
         s1_pix_ff <= req.pixel;
         s1_col_ff <= c_cur;
         s1_tag_ff.row <= POS_W'(r_cur - CW'(LBR));
         s1_tag_ff.col <= POS_W'(c_cur - CW'(LBR));
         s1_tag_ff.last <= (r_cur == CW'(IN_SIZE - 1)) && (c_cur == CW'(IN_SIZE - 1));
         s1_tag_ff.emit <= (r_cur >= CW'(LBR)) && (c_cur >= CW'(LBR));
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= acc && req.opcode == OP_PIXEL;
   end

   // Shift the column word up one row, put the new pixel on top and write it back
   always_comb begin
      col_word = rd_ff >> PIX_W;
      col_word[(LBR-1)*PIX_W +: PIX_W] = s1_pix_ff;
   end
   always_ff @(posedge clock) begin
      if (adv && s1_v_ff) lb_mem[s1_col_ff] <= col_word;
   end

   // Stage 2: shift the window
   logic [PIX_W-1:0] win_ff [0:KERNEL_SIZE-1][0:KERNEL_SIZE-1];
   logic [KK*PIX_W-1:0] win_flat;
   tag_type s2_tag_ff;
   logic s2_v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < KERNEL_SIZE; j++)
            for (int i = 0; i < KERNEL_SIZE; i++) win_ff[j][i] <= '0;
      end else if (adv && s1_v_ff) begin
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            for (int i = 0; i < KERNEL_SIZE - 1; i++) win_ff[j][i] <= win_ff[j][i+1];
            win_ff[j][KERNEL_SIZE-1] <= (j == LBR) ? s1_pix_ff : rd_ff[j*PIX_W +: PIX_W];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff && s1_tag_ff.emit;
   end
   always_ff @(posedge clock) begin
      if (adv) s2_tag_ff <= s1_tag_ff;
   end
   always_comb begin
      for (int j = 0; j < KERNEL_SIZE; j++)
         for (int i = 0; i < KERNEL_SIZE; i++)
            win_flat[(j*KERNEL_SIZE+i)*PIX_W +: PIX_W] = win_ff[j][i];
   end

   // Product tree
   logic signed [SUM_W-1:0] tree_sum;
   wconv_tree #(.KERNEL_SIZE(KERNEL_SIZE)) u_tree (
      .clock(clock), .enable(adv), .win(win_flat), .coef(coef_flat), .sum(tree_sum)
   );

   // Tag and valid delay line matching the tree
   logic v_ff [0:LV];
   tag_type t_ff [0:LV];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LV; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= s2_v_ff;
         for (int i = 1; i <= LV; i++) v_ff[i] <= v_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0] <= s2_tag_ff;
         for (int i = 1; i <= LV; i++) t_ff[i] <= t_ff[i-1];
      end
   end

   // Output queue absorbs results in flight during a stall
   localparam int AW = $clog2(FIFO_D);
   logic [SUM_W+2*POS_W:0] q_mem [0:FIFO_D-1];
   logic [AW-1:0] wp_ff, rp_ff;
   logic push, pop;
   assign push = adv && v_ff[LV];
   assign pop = rsp.valid && rsp.ready;
   always_ff @(posedge clock) begin
      if (push) q_mem[wp_ff] <= {tree_sum, t_ff[LV].row, t_ff[LV].col, t_ff[LV].last};
   end
   always_comb begin
      count_in = count_ff + FW'(push) - FW'(pop);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(FIFO_D - 1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == AW'(FIFO_D - 1)) ? '0 : rp_ff + 1'b1;
         count_ff <= count_in;
      end
   end
   assign rsp.valid = (count_ff != '0);
   assign {rsp.conv_sum, rsp.out_row, rsp.out_col, rsp.frame_last} = q_mem[rp_ff];

   `WC_ASSERT_IMPL(a_no_overflow, clock, reset, push, count_ff < FW'(FIFO_D))
   `WC_ASSERT_IMPL(a_no_underflow, clock, reset, pop, count_ff != '0)
   `WC_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, $stable(s1_v_ff))
endmodule
`default_nettype wire

/* sv/wconv_tree.sv */
`timescale 1ns / 1ps
`default_nettype none
// Registered adder tree over the window products: one product stage, then
// pairwise reduction stages. Advances only when enable is high.
module wconv_tree import wconv_pkg::*; #(
   parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
   input  wire logic clock,
   input  wire logic enable,
   input  wire logic [KERNEL_SIZE*KERNEL_SIZE*PIX_W-1:0] win,
   input  wire logic [KERNEL_SIZE*KERNEL_SIZE*COEF_W-1:0] coef,
   output logic signed [SUM_W-1:0] sum
);
   localparam int N = KERNEL_SIZE * KERNEL_SIZE;
   localparam int LV = $clog2(N);
   localparam int W = 2 ** LV;
   localparam int PW = PIX_W + COEF_W + 1;

   logic signed [SUM_W-1:0] lvl_ff [0:LV][0:W-1];
   logic signed [PW-1:0] prod [0:N-1];

   // Multiply each unsigned pixel by its signed coefficient at full width
   always_comb begin
      for (int i = 0; i < N; i++) begin
         prod[i] = $signed({1'b0, win[i*PIX_W +: PIX_W]}) *
                   $signed({{(PW-COEF_W){coef[i*COEF_W+COEF_W-1]}},
                            coef[i*COEF_W +: COEF_W]});
      end
   end

   // Form products into the leaves
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < W; i++) begin
            if (i < N) begin
               lvl_ff[0][i] <= SUM_W'(prod[i]);
            end else begin
               lvl_ff[0][i] <= '0;
            end
         end
      end
   end

   // Reduce pairwise, one level a stage
   for (genvar l = 1; l <= LV; l++) begin : g_lvl
      always_ff @(posedge clock) begin
         if (enable) begin
            for (int i = 0; i < (W >> l); i++) begin
               lvl_ff[l][i] <= lvl_ff[l-1][2*i] + lvl_ff[l-1][2*i+1];
            end
         end
      end
   end

   assign sum = lvl_ff[LV][0];
endmodule
`default_nettype wire
